// ===== hw/rtl/length_prefix_to_start_code_unit_macros.svh =====
// Assertion macros shared by the conversion unit's modules.
// Each expects clk and rst in scope; rst masks the check.
`ifndef LENGTH_PREFIX_TO_START_CODE_UNIT_MACROS_SVH
`define LENGTH_PREFIX_TO_START_CODE_UNIT_MACROS_SVH

// Property that must hold at every clock edge out of reset.
`define LPSC_ASSERT_ALWAYS(label, expr) \
  label: assert property (@(posedge clk) disable iff (rst) (expr)) \
    else $error("lpsc: invariant violated");

// Same-cycle implication.
`define LPSC_ASSERT_IMPLY(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("lpsc: implication violated");

// Next-cycle implication.
`define LPSC_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("lpsc: next-cycle implication violated");

`endif

// ===== hw/rtl/lpsc_pkg.sv =====
`timescale 1ns / 1ps

package lpsc_pkg;

  localparam int DATA_W = 8;
  localparam int SIZE_W = 25;   // unit_size, out_length, output_capacity
  localparam int PLEN_W = 3;    // length_prefix_bytes
  localparam int ACC_W  = 32;   // length prefix accumulator
  localparam int CFG_IDX_W = 1;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_PREFIX_BYTES    = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_OUTPUT_CAPACITY = 1'd1;

  localparam logic [PLEN_W-1:0] PREFIX_BYTES_RESET    = 3'd4;
  localparam logic [SIZE_W-1:0] OUTPUT_CAPACITY_RESET = 25'd16777216;

  // Result kinds
  localparam logic KIND_DATA    = 1'b0;
  localparam logic KIND_SUMMARY = 1'b1;

  // Status codes
  localparam logic STATUS_OK       = 1'b0;
  localparam logic STATUS_OVERFLOW = 1'b1;

  // NAL header fields
  localparam logic [4:0] NAL_TYPE_MASK = 5'h1F;
  localparam logic [4:0] NAL_TYPE_IDR  = 5'd5;

  // Start code 00 00 00 01, one byte per position
  function automatic logic [DATA_W-1:0] sync_seq_byte(input logic [1:0] idx);
    logic [DATA_W-1:0] b;
    case (idx)
      2'd3:    b = 8'h01;
      default: b = 8'h00;
    endcase
    return b;
  endfunction

  typedef struct packed {
    logic [DATA_W-1:0] in_byte;
    logic              unit_start;
    logic [SIZE_W-1:0] unit_size;
  } item_t;

  typedef struct packed {
    logic [PLEN_W-1:0] prefix_bytes;
    logic [SIZE_W-1:0] capacity;
  } cfg_t;

  // Everything one input word produces, drained one word at a time
  typedef struct packed {
    logic              sync_seq;     // four start-code words
    logic              data_valid;   // one copied NAL word
    logic [DATA_W-1:0] data;
    logic              summary;      // end-of-unit summary word
    logic [SIZE_W-1:0] length;
    logic              idr;
    logic              overflow;
  } bundle_t;

endpackage

// ===== hw/rtl/lpsc_if.sv =====
`timescale 1ns / 1ps

// Input channel: one access-unit byte per word
interface lpsc_in_if;
  logic                        valid;
  logic                        ready;
  logic [lpsc_pkg::DATA_W-1:0] in_byte;
  logic                        unit_start;
  logic [lpsc_pkg::SIZE_W-1:0] unit_size;

  modport source (output valid, in_byte, unit_start, unit_size, input ready);
  modport sink   (input valid, in_byte, unit_start, unit_size, output ready);
endinterface

// Output channel: data byte or end-of-unit summary
interface lpsc_out_if;
  logic                        valid;
  logic                        ready;
  logic                        item_kind;
  logic [lpsc_pkg::DATA_W-1:0] out_byte;
  logic [lpsc_pkg::SIZE_W-1:0] out_length;
  logic                        idr_seen;
  logic                        status;
  logic                        run_last;

  modport source (output valid, item_kind, out_byte, out_length, idr_seen, status,
                  run_last, input ready);
  modport sink   (input valid, item_kind, out_byte, out_length, idr_seen, status,
                  run_last, output ready);
endinterface

// ===== hw/rtl/lpsc_parser.sv =====
`timescale 1ns / 1ps

// Prefix parser: holds the per-unit state and works out, for one input
// word, the next state and the bundle of results it causes.
module lpsc_parser #(
  parameter int MAX_UNIT_BYTES = 16777216
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              fire,
  input  lpsc_pkg::item_t   item,
  input  lpsc_pkg::cfg_t    cfg,
  output lpsc_pkg::bundle_t bundle
);

  localparam int SIZE_W = lpsc_pkg::SIZE_W;
  localparam int ACC_W  = lpsc_pkg::ACC_W;
  localparam int PLEN_W = lpsc_pkg::PLEN_W;
  localparam int UW_RAW = $clog2(MAX_UNIT_BYTES + 1);
  localparam int UW     = (UW_RAW < SIZE_W) ? UW_RAW : SIZE_W;
  localparam longint SIZE_MAX = (longint'(1) << SIZE_W) - 1;
  localparam longint LIM_RAW  = (longint'(MAX_UNIT_BYTES) < SIZE_MAX) ?
                                longint'(MAX_UNIT_BYTES) : SIZE_MAX;
  localparam logic [SIZE_W-1:0] UNIT_LIMIT = SIZE_W'(LIM_RAW);

  localparam logic [1:0] PH_PREFIX = 2'd0;
  localparam logic [1:0] PH_COPY   = 2'd1;
  localparam logic [1:0] PH_STOP   = 2'd2;

  // State registers
  logic [UW-1:0]     bytes_consumed;
  logic [UW-1:0]     unit_total;
  logic [ACC_W-1:0]  length_accum;
  logic [PLEN_W-1:0] prefix_count;
  logic [UW-1:0]     nal_remaining;
  logic [SIZE_W-1:0] bytes_emitted;
  logic [1:0]        phase;
  logic              idr_flag;
  logic              overflow_flag;
  logic              at_nal_header;

  logic [UW-1:0]     bytes_consumed_next;
  logic [UW-1:0]     unit_total_next;
  logic [ACC_W-1:0]  length_accum_next;
  logic [PLEN_W-1:0] prefix_count_next;
  logic [UW-1:0]     nal_remaining_next;
  logic [SIZE_W-1:0] bytes_emitted_next;
  logic [1:0]        phase_next;
  logic              idr_flag_next;
  logic              overflow_flag_next;
  logic              at_nal_header_next;

  // Working values
  logic [SIZE_W-1:0] size_lim;
  logic [UW-1:0]     size_c;
  logic [PLEN_W-1:0] plen;
  logic              active;
  logic [UW-1:0]     before_cnt;
  logic [UW-1:0]     consumed_inc;
  logic [UW-1:0]     left_cnt;
  logic [ACC_W-1:0]  accum_shift;
  logic [PLEN_W-1:0] count_inc;
  logic [ACC_W:0]    need_total;
  logic              cap_over;
  logic [UW-1:0]     rem_dec;

  // Unit size clamp to 1..MAX_UNIT_BYTES
  always_comb begin
    size_lim = (item.unit_size > UNIT_LIMIT) ? UNIT_LIMIT : item.unit_size;
    size_c   = (size_lim == '0) ? UW'(1) : size_lim[UW-1:0];
  end

  // Prefix width clamp to 1..4
  always_comb begin
    if (cfg.prefix_bytes == '0) begin
      plen = PLEN_W'(1);
    end else if (cfg.prefix_bytes > PLEN_W'(4)) begin
      plen = PLEN_W'(4);
    end else begin
      plen = cfg.prefix_bytes;
    end
  end

  // Next state and results for one word
  always_comb begin
    bytes_consumed_next = bytes_consumed;
    unit_total_next     = unit_total;
    length_accum_next   = length_accum;
    prefix_count_next   = prefix_count;
    nal_remaining_next  = nal_remaining;
    bytes_emitted_next  = bytes_emitted;
    phase_next          = phase;
    idr_flag_next       = idr_flag;
    overflow_flag_next  = overflow_flag;
    at_nal_header_next  = at_nal_header;
    bundle              = '0;

    // a start word opens a fresh unit
    if (item.unit_start) begin
      unit_total_next     = size_c;
      bytes_consumed_next = '0;
      length_accum_next   = '0;
      prefix_count_next   = '0;
      nal_remaining_next  = '0;
      bytes_emitted_next  = '0;
      phase_next          = PH_PREFIX;
      idr_flag_next       = 1'b0;
      overflow_flag_next  = 1'b0;
      at_nal_header_next  = 1'b0;
    end

    active       = bytes_consumed_next < unit_total_next;
    before_cnt   = unit_total_next - bytes_consumed_next;
    consumed_inc = bytes_consumed_next + UW'(1);
    left_cnt     = unit_total_next - consumed_inc;
    accum_shift  = {length_accum_next[ACC_W-9:0], item.in_byte};
    count_inc    = prefix_count_next + PLEN_W'(1);
    need_total   = (ACC_W+1)'(bytes_emitted_next) + (ACC_W+1)'(4) +
                   (ACC_W+1)'(accum_shift);
    cap_over     = need_total > (ACC_W+1)'(cfg.capacity);
    rem_dec      = (nal_remaining_next != '0) ? nal_remaining_next - UW'(1)
                                              : nal_remaining_next;

    if (active) begin
      bytes_consumed_next = consumed_inc;
      case (phase_next)
        PH_PREFIX: begin
          if (prefix_count_next == '0 && before_cnt < UW'(plen)) begin
            phase_next = PH_STOP;
          end else if (count_inc >= plen) begin
            prefix_count_next = '0;
            length_accum_next = '0;
            if (accum_shift == '0 || accum_shift > ACC_W'(left_cnt)) begin
              phase_next = PH_STOP;
            end else if (cap_over) begin
              overflow_flag_next = 1'b1;
              phase_next         = PH_STOP;
            end else begin
              bundle.sync_seq    = 1'b1;
              bytes_emitted_next = bytes_emitted_next + SIZE_W'(4);
              nal_remaining_next = accum_shift[UW-1:0];
              at_nal_header_next = 1'b1;
              phase_next         = PH_COPY;
            end
          end else begin
            length_accum_next = accum_shift;
            prefix_count_next = count_inc;
          end
        end
        PH_COPY: begin
          if (at_nal_header_next &&
              (item.in_byte[4:0] & lpsc_pkg::NAL_TYPE_MASK) == lpsc_pkg::NAL_TYPE_IDR) begin
            idr_flag_next = 1'b1;
          end
          at_nal_header_next = 1'b0;
          bundle.data_valid  = 1'b1;
          bundle.data        = item.in_byte;
          bytes_emitted_next = bytes_emitted_next + SIZE_W'(1);
          nal_remaining_next = rem_dec;
          if (rem_dec == '0) begin
            phase_next = PH_PREFIX;
          end
        end
        default: begin
        end
      endcase

      // final byte of the unit: summary
      if (consumed_inc == unit_total_next) begin
        bundle.summary  = 1'b1;
        bundle.length   = bytes_emitted_next;
        bundle.idr      = idr_flag_next;
        bundle.overflow = overflow_flag_next ? lpsc_pkg::STATUS_OVERFLOW
                                             : lpsc_pkg::STATUS_OK;
        phase_next      = PH_STOP;
      end
    end
  end

  // State update, once per processed word
  always_ff @(posedge clk) begin
    if (rst) begin
      bytes_consumed <= '0;
      unit_total     <= '0;
      length_accum   <= '0;
      prefix_count   <= '0;
      nal_remaining  <= '0;
      bytes_emitted  <= '0;
      phase          <= PH_PREFIX;
      idr_flag       <= 1'b0;
      overflow_flag  <= 1'b0;
      at_nal_header  <= 1'b0;
    end else if (fire) begin
      bytes_consumed <= bytes_consumed_next;
      unit_total     <= unit_total_next;
      length_accum   <= length_accum_next;
      prefix_count   <= prefix_count_next;
      nal_remaining  <= nal_remaining_next;
      bytes_emitted  <= bytes_emitted_next;
      phase          <= phase_next;
      idr_flag       <= idr_flag_next;
      overflow_flag  <= overflow_flag_next;
      at_nal_header  <= at_nal_header_next;
    end
  end

`include "length_prefix_to_start_code_unit_macros.svh"

  // a partial prefix never holds a full four bytes
  `LPSC_ASSERT_ALWAYS(a_prefix_count_range, prefix_count <= PLEN_W'(3))
  // copying always has NAL bytes left
  `LPSC_ASSERT_IMPLY(a_copy_nonempty, phase == PH_COPY, nal_remaining != '0)
  // never consume past the unit
  `LPSC_ASSERT_ALWAYS(a_consumed_bound, bytes_consumed <= unit_total)

endmodule

// ===== hw/rtl/lpsc_emitter.sv =====
`timescale 1ns / 1ps

// Result register: holds one word's bundle and drains it one result
// word per cycle onto the output channel while that channel is ready.
module lpsc_emitter (
  input  logic                clk,
  input  logic                rst,
  input  logic                load,
  input  lpsc_pkg::bundle_t   bundle,
  output logic                can_load,
  lpsc_out_if.source          out_ch
);

  logic              busy;
  logic [2:0]        pos;
  lpsc_pkg::bundle_t bnd;

  logic [2:0] n_data;
  logic [2:0] total;
  logic       last;
  logic       take;

  // position decode
  always_comb begin
    n_data = bnd.sync_seq ? 3'd4 : (bnd.data_valid ? 3'd1 : 3'd0);
    total  = n_data + {2'b00, bnd.summary};
    last   = (pos == total - 3'd1);
    take   = busy && out_ch.ready;
    can_load = !busy || (take && last);
  end

  // output word
  always_comb begin
    out_ch.valid    = busy;
    out_ch.run_last = last;
    if (pos < n_data) begin
      out_ch.item_kind  = lpsc_pkg::KIND_DATA;
      out_ch.out_byte   = bnd.sync_seq ? lpsc_pkg::sync_seq_byte(pos[1:0]) : bnd.data;
      out_ch.out_length = '0;
      out_ch.idr_seen   = 1'b0;
      out_ch.status     = lpsc_pkg::STATUS_OK;
    end else begin
      out_ch.item_kind  = lpsc_pkg::KIND_SUMMARY;
      out_ch.out_byte   = '0;
      out_ch.out_length = bnd.length;
      out_ch.idr_seen   = bnd.idr;
      out_ch.status     = bnd.overflow;
    end
  end

  // control
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      pos  <= '0;
    end else if (load) begin
      busy <= 1'b1;
      pos  <= '0;
    end else if (take) begin
      if (last) begin
        busy <= 1'b0;
      end else begin
        pos <= pos + 3'd1;
      end
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (load) begin
      bnd <= bundle;
    end
  end

`include "length_prefix_to_start_code_unit_macros.svh"

  // summary is always the final result of its word
  `LPSC_ASSERT_IMPLY(a_summary_last, busy && out_ch.item_kind == lpsc_pkg::KIND_SUMMARY,
                     out_ch.run_last)
  // drain position stays inside the bundle
  `LPSC_ASSERT_IMPLY(a_pos_range, busy, pos < total)

endmodule

// ===== hw/rtl/length_prefix_to_start_code_unit.sv =====
`timescale 1ns / 1ps

// Length-prefix to start-code converter. Takes one access unit as a byte
// stream (unit_start and unit_size on its first byte) and emits the unit with
// every 1- to 4-byte big-endian NAL length replaced by 00 00 00 01, then one
// summary word with output length, IDR flag and overflow status after the
// unit's last byte. Input bytes are taken at one per cycle as long as each
// yields at most one result and the output channel is ready; a byte that
// completes a length prefix yields four start-code words, and the input
// holds off while the result register drains them one word per cycle. A
// byte whose result is a data word plus the summary also holds the input
// until both words drain. An accepted byte passes the input register, then
// the result register, before its first result. Registers: index 0 = length
// prefix width, index 1 = output capacity; write them only between units.
module length_prefix_to_start_code_unit #(
  parameter int MAX_UNIT_BYTES = 16777216
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               cfg_write_en,
  input  logic [lpsc_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [lpsc_pkg::SIZE_W-1:0]        cfg_data,
  lpsc_in_if.sink                            in_ch,
  lpsc_out_if.source                         out_ch
);

  lpsc_pkg::cfg_t    cfg;
  lpsc_pkg::item_t   item;
  lpsc_pkg::bundle_t bundle;
  logic              item_valid;
  logic              can_load;
  logic              fire;
  logic              bundle_any;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.prefix_bytes <= lpsc_pkg::PREFIX_BYTES_RESET;
      cfg.capacity     <= lpsc_pkg::OUTPUT_CAPACITY_RESET;
    end else if (cfg_write_en) begin
      case (cfg_index)
        lpsc_pkg::REG_PREFIX_BYTES:    cfg.prefix_bytes <= cfg_data[lpsc_pkg::PLEN_W-1:0];
        lpsc_pkg::REG_OUTPUT_CAPACITY: cfg.capacity     <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  // input register: takes a new word when empty or whenever the held one moves on
  assign fire         = item_valid && can_load;
  assign in_ch.ready  = !item_valid || fire;

  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (in_ch.valid && in_ch.ready) begin
      item_valid <= 1'b1;
    end else if (fire) begin
      item_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      item.in_byte    <= in_ch.in_byte;
      item.unit_start <= in_ch.unit_start;
      item.unit_size  <= in_ch.unit_size;
    end
  end

  lpsc_parser #(
    .MAX_UNIT_BYTES(MAX_UNIT_BYTES)
  ) u_parser (
    .clk    (clk),
    .rst    (rst),
    .fire   (fire),
    .item   (item),
    .cfg    (cfg),
    .bundle (bundle)
  );

  assign bundle_any = bundle.sync_seq | bundle.data_valid | bundle.summary;

  lpsc_emitter u_emitter (
    .clk      (clk),
    .rst      (rst),
    .load     (fire && bundle_any),
    .bundle   (bundle),
    .can_load (can_load),
    .out_ch   (out_ch)
  );

endmodule
